// ===== sv/stack_with_bottom_increment_unit_assert.svh =====
// Assertion macros shared by the stack unit.
`ifndef STACK_WITH_BOTTOM_INCREMENT_UNIT_ASSERT_SVH
`define STACK_WITH_BOTTOM_INCREMENT_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define SBI_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define SBI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/sbi_pkg.sv =====
`timescale 1ns / 1ps
package sbi_pkg;

  // Operation handed to every cell.
  typedef enum logic [1:0] {
    OP_PUSH = 2'd0,
    OP_POP  = 2'd1,
    OP_ADD  = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_TOP_VALID = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_POP_EMPTY = 2'd2,
    ST_PUSH_FULL = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]         req_type;
    logic signed [31:0] push_value;
    logic [15:0]        bottom_count;
    logic signed [31:0] add_amount;
  } req_t;

  typedef struct packed {
    status_t            status;
    logic signed [31:0] top_value;
    logic signed [31:0] popped_value;
  } res_t;

  // Broadcast to the cell row each cycle; pushed data enters at the top cell.
  typedef struct packed {
    op_t         op;
    logic [31:0] add_amount;
  } cell_cmd_t;

endpackage

// ===== sv/sbi_cell.sv =====
`timescale 1ns / 1ps
module sbi_cell import sbi_pkg::*; #(
  parameter int INDEX = 0,
  parameter int FW    = 7
) (
  input  logic            clk,
  input  cell_cmd_t       cmd,
  input  logic [FW-1:0]   fill,
  input  logic [FW-1:0]   thresh,
  input  logic [31:0]     above,
  input  logic [31:0]     below,
  output logic [31:0]     data
);

  // Cell position counted from the top of the stack.
  localparam logic [FW-1:0] IDX = FW'(INDEX);

  logic        hit;
  logic [31:0] data_next;

  // Cells from thresh up to fill-1 hold the bottom entries being bumped.
  assign hit = (IDX >= thresh) && (IDX < fill);

  always_comb begin
    data_next = data;
    case (cmd.op)
      OP_PUSH: data_next = above;
      OP_POP:  data_next = below;
      OP_ADD:  if (hit) data_next = data + cmd.add_amount;
      OP_NONE: data_next = data;
      default: data_next = data;
    endcase
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule

// ===== sv/stack_with_bottom_increment_unit.sv =====
`timescale 1ns / 1ps
// Channel   | Handshake          | Payload            | Direction
// ----------+--------------------+--------------------+----------
// request   | start / busy       | req    (req_t)     | in
// result    | done (1-cycle)     | result (res_t)     | out
//
// One request per clock unless busy: every cell updates in the cycle the
// request is taken, so throughput is set by the per-cell 32-bit adder
// on an add. The result strobes on done in the cycle after its request.
// busy is high only while rst is asserted and in the first cycle after it.
// The receiver cannot stall; results are never held back.
// Stack contents are not cleared on reset; the fill count and done are.
module stack_with_bottom_increment_unit import sbi_pkg::*; #(
  parameter int STACK_DEPTH = 64
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  req_t req,
  output logic done,
  output res_t result
);

`include "stack_with_bottom_increment_unit_assert.svh"

  localparam int FW = $clog2(STACK_DEPTH + 1);
  localparam int CW = (FW > 16) ? FW : 16;
  localparam logic [FW-1:0] DEPTH_W = FW'(STACK_DEPTH);

  // Registers
  logic          init_q;      // one cycle of busy after reset
  logic [FW-1:0] fill;
  logic          done_q;
  status_t       status_q;
  logic [31:0]   popped_q;

  logic [FW-1:0] fill_next;
  status_t       status_next;
  logic [31:0]   popped_next;

  logic          accepted;
  logic          full;
  logic          empty;
  cell_cmd_t     cmd;
  logic [CW-1:0] fill_x;
  logic [CW-1:0] count_x;
  logic [FW-1:0] thresh;

  // Cell row, index 0 is the top of the stack.
  logic [31:0]   cell_q [STACK_DEPTH];

  assign busy     = rst | init_q;
  assign accepted = start & ~busy;
  assign full     = (fill == DEPTH_W);
  assign empty    = (fill == '0);

  // First cell index that belongs to the bumped bottom range.
  assign fill_x  = CW'(fill);
  assign count_x = CW'(req.bottom_count);
  assign thresh  = (count_x >= fill_x) ? '0 : FW'(fill_x - count_x);

  // Rejected pushes and pops become no-ops in the row.
  always_comb begin
    cmd.add_amount = req.add_amount;
    cmd.op         = OP_NONE;
    fill_next      = fill;
    status_next    = empty ? ST_EMPTY : ST_TOP_VALID;
    popped_next    = '0;
    if (accepted) begin
      case (req.req_type)
        OP_PUSH: begin
          if (full) begin
            status_next = ST_PUSH_FULL;
          end else begin
            cmd.op      = OP_PUSH;
            fill_next   = fill + 1'b1;
            status_next = ST_TOP_VALID;
          end
        end
        OP_POP: begin
          if (empty) begin
            status_next = ST_POP_EMPTY;
          end else begin
            cmd.op      = OP_POP;
            fill_next   = fill - 1'b1;
            popped_next = cell_q[0];
            status_next = (fill == FW'(1)) ? ST_EMPTY : ST_TOP_VALID;
          end
        end
        OP_ADD:  cmd.op = OP_ADD;
        default: cmd.op = OP_NONE;
      endcase
    end
  end

  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    logic [31:0] above_d;
    logic [31:0] below_d;
    if (i == 0) begin : g_top
      assign above_d = req.push_value;
    end else begin : g_mid
      assign above_d = cell_q[i-1];
    end
    if (i == STACK_DEPTH - 1) begin : g_last
      assign below_d = cell_q[i];
    end else begin : g_inner
      assign below_d = cell_q[i+1];
    end
    sbi_cell #(
      .INDEX (i),
      .FW    (FW)
    ) u_cell (
      .clk    (clk),
      .cmd    (cmd),
      .fill   (fill),
      .thresh (thresh),
      .above  (above_d),
      .below  (below_d),
      .data   (cell_q[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      init_q <= 1'b1;
      fill   <= '0;
      done_q <= 1'b0;
    end else begin
      init_q <= 1'b0;
      fill   <= fill_next;
      done_q <= accepted;
    end
  end

  always_ff @(posedge clk) begin
    status_q <= status_next;
    popped_q <= popped_next;
  end

  // Top is read from the row after the update has landed.
  assign done                = done_q;
  assign result.status       = status_q;
  assign result.top_value    = empty ? 32'sd0 : cell_q[0];
  assign result.popped_value = popped_q;

  `SBI_ASSERT_NEXT(a_done_follows, accepted, done, "result strobe missing")
  `SBI_ASSERT_NEXT(a_no_spurious, !accepted, !done, "result without request")
  `SBI_ASSERT_NOW(a_fill_bound, 1'b1, fill <= DEPTH_W, "fill beyond depth")
  `SBI_ASSERT_NEXT(a_push_fill, accepted && req.req_type == OP_PUSH && !full,
    fill == $past(fill) + 1'b1, "push did not grow fill")
  `SBI_ASSERT_NOW(a_empty_zero, done && result.status == ST_EMPTY,
    result.top_value == 32'sd0, "empty result carries a top value")

endmodule
